### rtl/core/rtcs_pkg.sv
// Shared types and constants for the three-wire RTC serial master.
`default_nettype none
package rtcs_pkg;

  localparam int DATA_BITS = 8;
  localparam int BIT_POS_W = 5;
  localparam int SHIFT_W   = 2 * DATA_BITS;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } rtcs_op_t;

  // Register index of the only configuration register.
  localparam logic REG_HALF_PERIOD = 1'b0;

  typedef struct packed {
    logic [BIT_POS_W-1:0] bit_position;
    logic                 half_phase;
    logic [7:0]           divider_count;
    logic [SHIFT_W-1:0]   out_shift;
    logic [DATA_BITS-1:0] in_shift;
    logic                 reading;
    logic                 active;
    logic                 clock_level;
    logic                 enable_level;
    logic                 drive_data;
  } rtcs_state_t;

  localparam rtcs_state_t STATE_RESET = '{
    bit_position:  '0,
    half_phase:    1'b0,
    divider_count: '0,
    out_shift:     '0,
    in_shift:      '0,
    reading:       1'b0,
    active:        1'b0,
    clock_level:   1'b0,
    enable_level:  1'b0,
    drive_data:    1'b1
  };

endpackage
`default_nettype wire

### rtl/core/three_wire_rtc_serial_master_unit.sv
// Top level of the three-wire RTC serial master: state, result register, config port.
//
//   Channel | Direction | Handshake            | Beat contents
//   in_     | input     | in_valid / in_ready  | operation, address, write data, data pin
//   out_    | output    | out_valid / out_ready| pin levels, busy, read valid, read data
//   cfg_    | input     | APB, pready tied 1   | half period in ticks (register 0)
//
// Each input beat is handled combinationally; its result appears in the output
// register on the next cycle; with out_ready high, one beat per cycle is sustained.
// The only stall is a held result: in_ready drops while out_valid is high and
// out_ready is low. Synchronous active-low reset returns the link to idle with
// the data line driven and the half period set to one tick.
`default_nettype none
module three_wire_rtc_serial_master_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [6:0]                       in_reg_address,
  input  logic [rtcs_pkg::DATA_BITS-1:0]   in_write_data,
  input  logic                             in_data_pin_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_enable_pin,
  output logic                             out_clock_pin,
  output logic                             out_data_pin_out,
  output logic                             out_data_drive_enable,
  output logic                             out_busy_res,
  output logic                             out_read_valid,
  output logic [rtcs_pkg::DATA_BITS-1:0]   out_read_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [rtcs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [rtcs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [rtcs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import rtcs_pkg::*;

  rtcs_state_t          state_r;
  rtcs_state_t          state_nxt;
  logic                 read_done;
  logic [7:0]           half_period;
  logic                 in_fire;
  logic                 out_valid_r;
  logic                 enable_r;
  logic                 clock_r;
  logic                 data_out_r;
  logic                 drive_r;
  logic                 busy_r;
  logic                 read_valid_r;
  logic [DATA_BITS-1:0] read_data_r;

  rtcs_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .half_period (half_period)
  );

  rtcs_step u_step (
    .cur         (state_r),
    .half_period (half_period),
    .operation   (in_operation),
    .reg_address (in_reg_address),
    .write_data  (in_write_data),
    .data_pin_in (in_data_pin_in),
    .nxt         (state_nxt),
    .read_done   (read_done)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload is loaded with every accepted beat and needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      enable_r     <= state_nxt.enable_level;
      clock_r      <= state_nxt.clock_level;
      data_out_r   <= state_nxt.drive_data & state_nxt.out_shift[0];
      drive_r      <= state_nxt.drive_data;
      busy_r       <= state_nxt.active;
      read_valid_r <= read_done;
      read_data_r  <= state_nxt.in_shift;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_enable_pin        = enable_r;
  assign out_clock_pin         = clock_r;
  assign out_data_pin_out      = data_out_r;
  assign out_data_drive_enable = drive_r;
  assign out_busy_res          = busy_r;
  assign out_read_valid        = read_valid_r;
  assign out_read_data         = read_data_r;

  a_idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.active |-> (!state_r.enable_level && !state_r.clock_level))
    else $error("idle link with enable or clock high");

  a_release_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.drive_data |-> state_r.reading)
    else $error("data line released outside a read");

  a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bit_position <= BIT_POS_W'(2 * DATA_BITS))
    else $error("bit position past end of transaction");

  a_read_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && read_valid_r) |-> (!busy_r && !enable_r))
    else $error("read completion reported while link busy");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire

### rtl/core/rtcs_apb_regs.sv
// APB-style configuration register block holding the half period setting.
`default_nettype none
module rtcs_apb_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rtcs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rtcs_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rtcs_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [7:0]                       half_period
);
  import rtcs_pkg::*;

  logic [7:0] half_period_r;
  logic       reg_index;

  assign reg_index   = paddr[CFG_ADDR_W-1];
  assign pready      = 1'b1;
  assign half_period = half_period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RESET;
    end else if (psel && penable && pwrite && (reg_index == REG_HALF_PERIOD)) begin
      half_period_r <= pwdata[7:0];
    end
  end

  always_comb begin
    if (reg_index == REG_HALF_PERIOD) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, half_period_r};
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

### rtl/core/rtcs_step.sv
// Next-state logic for one input beat: divider, bit sequencing and shifting.
`default_nettype none
module rtcs_step (
  input  rtcs_pkg::rtcs_state_t             cur,
  input  logic [7:0]                        half_period,
  input  logic [1:0]                        operation,
  input  logic [6:0]                        reg_address,
  input  logic [rtcs_pkg::DATA_BITS-1:0]    write_data,
  input  logic                              data_pin_in,
  output rtcs_pkg::rtcs_state_t             nxt,
  output logic                              read_done
);
  import rtcs_pkg::*;

  localparam logic [BIT_POS_W-1:0] BP_HALF = BIT_POS_W'(DATA_BITS);
  localparam logic [BIT_POS_W-1:0] BP_END  = BIT_POS_W'(2 * DATA_BITS);

  logic [7:0]           hp;
  logic                 read_part;
  logic [BIT_POS_W-1:0] bp_inc;
  logic                 period_end;
  logic [7:0]           cmd;

  always_comb begin
    hp         = (half_period == 8'd0) ? 8'd1 : half_period;
    read_part  = cur.reading && (cur.bit_position >= BP_HALF);
    bp_inc     = cur.bit_position + 1'b1;
    period_end = ({1'b0, cur.divider_count} + 9'd1) >= {1'b0, hp};
    cmd        = {reg_address, operation == OP_READ};
    nxt        = cur;
    read_done  = 1'b0;

    case (operation)
      OP_READ, OP_WRITE: begin
        if (!cur.active) begin
          nxt.out_shift     = {(operation == OP_WRITE) ? write_data : 8'd0, cmd};
          nxt.reading       = (operation == OP_READ);
          nxt.active        = 1'b1;
          nxt.enable_level  = 1'b1;
          nxt.clock_level   = 1'b0;
          nxt.drive_data    = 1'b1;
          nxt.bit_position  = '0;
          nxt.half_phase    = 1'b0;
          nxt.divider_count = '0;
        end
      end
      OP_TICK: begin
        if (cur.active) begin
          if (period_end) begin
            nxt.divider_count = '0;
            if (!cur.half_phase) begin
              // End of a low half: a read samples the line just before the rise.
              if (read_part) begin
                nxt.in_shift     = {data_pin_in, cur.in_shift[DATA_BITS-1:1]};
                nxt.bit_position = bp_inc;
              end
              if (read_part && (bp_inc >= BP_END)) begin
                nxt.active       = 1'b0;
                nxt.enable_level = 1'b0;
                nxt.clock_level  = 1'b0;
                nxt.half_phase   = 1'b0;
                read_done        = 1'b1;
              end else begin
                nxt.clock_level = 1'b1;
                nxt.half_phase  = 1'b1;
              end
            end else begin
              nxt.clock_level = 1'b0;
              nxt.half_phase  = 1'b0;
              if (!read_part) begin
                nxt.out_shift    = cur.out_shift >> 1;
                nxt.bit_position = bp_inc;
                if (!cur.reading && (bp_inc >= BP_END)) begin
                  nxt.active       = 1'b0;
                  nxt.enable_level = 1'b0;
                end else if (cur.reading && (bp_inc == BP_HALF)) begin
                  nxt.drive_data = 1'b0;
                end
              end
            end
          end else begin
            nxt.divider_count = cur.divider_count + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
